// ----- rtl/pmot_pkg.sv -----
package pmot_pkg;

  localparam int MAX_COMPONENTS = 4;
  localparam int OUTLIER_DEPTH  = 1024;
  localparam int COS_TABLE_BITS = 10;

  localparam int ADDR_W  = $clog2(OUTLIER_DEPTH);
  localparam int TOTAL_W = ADDR_W + 1;
  localparam int ACC_W   = 36;
  localparam int ROM_SH  = 16 - COS_TABLE_BITS;
  localparam int QTR_W   = COS_TABLE_BITS - 2;
  localparam int QTR_N   = 1 << QTR_W;

  localparam logic [31:0] START_LENGTH_RST = 32'd86400;
  localparam logic signed [ACC_W-1:0] HALF_Q30 = 36'sd536870912;

  localparam logic [2:0] REG_DC_GAIN      = 3'd0;
  localparam logic [2:0] REG_START_LENGTH = 3'd1;
  localparam logic [2:0] REG_COMP_COUNT   = 3'd2;
  localparam logic [2:0] REG_COMP_A       = 3'd3;
  localparam logic [2:0] REG_COMP_B       = 3'd4;
  localparam logic [2:0] REG_COMP_C       = 3'd5;
  localparam logic [2:0] REG_COMP_D       = 3'd6;

  localparam logic [0:0] MODE_ADD      = 1'b0;
  localparam logic [0:0] MODE_RETRIEVE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] query_time;
    logic        observed_bit;
  } in_item_t;

  typedef struct packed {
    logic state_bit;
    logic outlier_added;
    logic store_full;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_COMP,
    ST_DIV,
    ST_LOOKUP,
    ST_ACC,
    ST_FINISH
  } state_e;

  typedef logic [14:0] cos_rom_t [QTR_N+1];

  // quarter-wave cosine, Q30 polynomial, rounded to Q1.15 magnitude
  function automatic logic [14:0] quarter_cos_q15(input longint unsigned p);
    longint unsigned u, u2, b, t, v, r;
    u  = p << 16;
    u2 = (u * u) >> 30;
    b  = 64'd22401992 - ((u2 * 64'd987046) >> 30);
    b  = 64'd272375557 - ((u2 * b) >> 30);
    b  = 64'd1324675879 - ((u2 * b) >> 30);
    t  = (u2 * b) >> 30;
    v  = (t >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - t;
    r  = (v + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[14:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k <= QTR_N; k++) begin
      rom[k] = quarter_cos_q15(longint'(k) << ROM_SH);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- rtl/pmot_ram.sv -----
module pmot_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/pmot_div.sv -----
module pmot_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmot_pkg::div_req_t  req_i,
  output pmot_pkg::div_rsp_t  rsp_o
);

  // restoring divider: low 16 quotient bits of (dividend << 16) / divisor, one bit a cycle
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q, num_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      num_d  = {req_i.dividend, 16'd0};
      den_d  = req_i.divisor;
      rem_d  = '0;
    end else if (run_q) begin
      num_d  = {num_q[62:0], 1'b0};
      rem_d  = fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quot_d = {quot_q[14:0], fits};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- rtl/periodic_model_outlier_tracker_top.sv -----
// Periodic binary-state predictor with an outlier store. Raise start for one
// cycle while busy is low; the block then works on that item alone and
// returns exactly one result, shown on res_o for a single cycle with
// res_strobe_o high. The receiver cannot stall, so sample res_o on the strobe.
// An item goes through each of the components in use (0..4): each one runs
// one 64-step pass of the shared bit-serial divider (skipped while the sample
// counter is zero), then a multiply and table lookup, then an accumulate. A
// retrieve item first scans the outlier memory from its start, one entry read
// and checked at a time, up to the first entry above query_time or the end.
// Configuration writes are taken only while busy and start are both low;
// writing start_length also reloads the sample counter.
module periodic_model_outlier_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pmot_pkg::in_item_t item_i,
  output logic               res_strobe_o,
  output pmot_pkg::result_t  res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  pmot_pkg::state_e state_q, state_d;

  logic [15:0] dc_gain_q;
  logic [2:0]  comp_count_q;
  logic [47:0] comp_q [4];

  logic [31:0] sample_count_q;
  logic [pmot_pkg::TOTAL_W-1:0] total_q;

  logic        mode_q;
  logic        obs_q;
  logic [31:0] t_q;
  logic [pmot_pkg::TOTAL_W-1:0] scan_q, scan_d;
  logic [2:0]  comp_idx_q, comp_idx_d;
  logic [15:0] f_q, f_d;
  logic signed [31:0] term_q;
  logic signed [pmot_pkg::ACC_W-1:0] acc_q, acc_d;

  logic [2:0]  n_comp;
  logic [47:0] cur_comp;
  logic        accept;
  logic        cfg_we;

  logic [15:0] phase_sum;
  logic [pmot_pkg::COS_TABLE_BITS-1:0] rom_idx;
  logic [1:0]  quad;
  logic [pmot_pkg::QTR_W-1:0] qk;
  logic [pmot_pkg::QTR_W:0]   rom_addr;
  logic [14:0] cos_mag;
  logic signed [15:0] cos_val;

  pmot_pkg::div_req_t div_req;
  pmot_pkg::div_rsp_t div_rsp;

  logic        ram_we;
  logic [31:0] ram_rdata;

  logic        pred;
  logic        bit_val;
  logic        mismatch;
  logic        room;
  logic        fin;

  assign accept      = start && !busy;
  assign busy        = state_q != pmot_pkg::ST_IDLE;
  assign cfg_ready_o = !busy && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign n_comp   = (comp_count_q > 3'(pmot_pkg::MAX_COMPONENTS)) ?
                    3'(pmot_pkg::MAX_COMPONENTS) : comp_count_q;
  assign cur_comp = comp_q[comp_idx_q[1:0]];

  // cosine from the quarter-wave table
  assign phase_sum = f_q + cur_comp[15:0];
  assign rom_idx   = phase_sum[15:pmot_pkg::ROM_SH];
  assign quad      = rom_idx[pmot_pkg::COS_TABLE_BITS-1 -: 2];
  assign qk        = rom_idx[pmot_pkg::QTR_W-1:0];
  assign rom_addr  = quad[0] ? ((pmot_pkg::QTR_W+1)'(pmot_pkg::QTR_N) - {1'b0, qk})
                             : {1'b0, qk};
  assign cos_mag   = pmot_pkg::COS_ROM[rom_addr];
  assign cos_val   = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, cos_mag})
                                                    : $signed({1'b0, cos_mag});

  assign div_req.start    = (state_q == pmot_pkg::ST_COMP) && (comp_idx_q != n_comp)
                            && (sample_count_q != 32'd0);
  assign div_req.dividend = t_q * cur_comp[31:16];
  assign div_req.divisor  = sample_count_q;

  pmot_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pred     = (mode_q == pmot_pkg::MODE_RETRIEVE) ? (acc_q >= pmot_pkg::HALF_Q30)
                                                        : (acc_q > pmot_pkg::HALF_Q30);
  assign bit_val  = pred ^ ((mode_q == pmot_pkg::MODE_RETRIEVE) ? scan_q[0] : total_q[0]);
  assign mismatch = (mode_q == pmot_pkg::MODE_ADD) && (bit_val != obs_q);
  assign room     = total_q < pmot_pkg::TOTAL_W'(pmot_pkg::OUTLIER_DEPTH);
  assign fin      = state_q == pmot_pkg::ST_FINISH;
  assign ram_we   = fin && mismatch && room;

  pmot_ram #(
    .Width (32),
    .Depth (pmot_pkg::OUTLIER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[pmot_pkg::ADDR_W-1:0]),
    .wdata_i (sample_count_q),
    .raddr_i (scan_q[pmot_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    comp_idx_d = comp_idx_q;
    f_d        = f_q;
    acc_d      = acc_q;
    case (state_q)
      pmot_pkg::ST_IDLE: begin
        if (accept) begin
          scan_d     = '0;
          comp_idx_d = '0;
          acc_d      = {{5{dc_gain_q[15]}}, dc_gain_q, 15'd0};
          state_d    = (item_i.mode == pmot_pkg::MODE_RETRIEVE) ? pmot_pkg::ST_SCAN_RD
                                                                : pmot_pkg::ST_COMP;
        end
      end
      pmot_pkg::ST_SCAN_RD: begin
        state_d = (scan_q == total_q) ? pmot_pkg::ST_COMP : pmot_pkg::ST_SCAN_CHK;
      end
      pmot_pkg::ST_SCAN_CHK: begin
        if (t_q < ram_rdata) begin
          state_d = pmot_pkg::ST_COMP;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = pmot_pkg::ST_SCAN_RD;
        end
      end
      pmot_pkg::ST_COMP: begin
        if (comp_idx_q == n_comp) begin
          state_d = pmot_pkg::ST_FINISH;
        end else if (sample_count_q == 32'd0) begin
          f_d     = '0;
          state_d = pmot_pkg::ST_LOOKUP;
        end else begin
          state_d = pmot_pkg::ST_DIV;
        end
      end
      pmot_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          f_d     = div_rsp.quot;
          state_d = pmot_pkg::ST_LOOKUP;
        end
      end
      pmot_pkg::ST_LOOKUP: begin
        state_d = pmot_pkg::ST_ACC;
      end
      pmot_pkg::ST_ACC: begin
        acc_d      = acc_q + {{3{term_q[31]}}, term_q, 1'b0};
        comp_idx_d = comp_idx_q + 3'd1;
        state_d    = pmot_pkg::ST_COMP;
      end
      pmot_pkg::ST_FINISH: begin
        state_d = pmot_pkg::ST_IDLE;
      end
      default: begin
        state_d = pmot_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pmot_pkg::ST_IDLE;
      dc_gain_q      <= '0;
      comp_count_q   <= '0;
      comp_q         <= '{default: '0};
      sample_count_q <= pmot_pkg::START_LENGTH_RST;
      total_q        <= '0;
      scan_q         <= '0;
      comp_idx_q     <= '0;
      res_strobe_o   <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      comp_idx_q   <= comp_idx_d;
      res_strobe_o <= fin;
      if (cfg_we) begin
        case (cfg_index_i)
          pmot_pkg::REG_DC_GAIN: dc_gain_q <= cfg_data_i[15:0];
          pmot_pkg::REG_START_LENGTH: begin
            sample_count_q <= cfg_data_i[31:0];
          end
          pmot_pkg::REG_COMP_COUNT: comp_count_q <= cfg_data_i[2:0];
          pmot_pkg::REG_COMP_A:     comp_q[0] <= cfg_data_i;
          pmot_pkg::REG_COMP_B:     comp_q[1] <= cfg_data_i;
          pmot_pkg::REG_COMP_C:     comp_q[2] <= cfg_data_i;
          pmot_pkg::REG_COMP_D:     comp_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      // advance the sample counter and append the outlier at the end of an add
      if (fin && mode_q == pmot_pkg::MODE_ADD) begin
        sample_count_q <= sample_count_q + 32'd1;
      end
      if (ram_we) begin
        total_q <= total_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    acc_q  <= acc_d;
    term_q <= $signed(cur_comp[47:32]) * cos_val;
    if (accept) begin
      mode_q <= item_i.mode;
      obs_q  <= item_i.observed_bit;
      t_q    <= (item_i.mode == pmot_pkg::MODE_RETRIEVE) ? item_i.query_time
                                                         : sample_count_q;
    end
    if (fin) begin
      res_o.state_bit     <= bit_val;
      res_o.outlier_added <= mismatch && room;
      res_o.store_full    <= mismatch && !room;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("item accepted but block not busy");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !(res_o.outlier_added && res_o.store_full))
    else $error("outlier added and store full together");
  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.outlier_added |-> total_q == $past(total_q) + 1'b1)
    else $error("outlier count did not advance");
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pmot_pkg::TOTAL_W'(pmot_pkg::OUTLIER_DEPTH))
    else $error("outlier count beyond store depth");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

class pmot_scoreboard;
  // predictor copy of the registers and state
  logic [15:0] gain;
  logic [31:0] period;
  logic [2:0]  n_comp;
  logic [47:0] comp [4];
  logic [31:0] cur_len;
  logic [31:0] outlier_pos [pmot_pkg::OUTLIER_DEPTH];
  int unsigned n_outliers;

  pmot_pkg::result_t expected_q [$];
  int unsigned errors, n_add, n_ret, n_added, n_full;

  function new();
    gain = '0;
    period = pmot_pkg::START_LENGTH_RST;
    n_comp = '0;
    foreach (comp[i]) comp[i] = '0;
    cur_len = pmot_pkg::START_LENGTH_RST;
    n_outliers = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] data);
    case (idx)
      pmot_pkg::REG_DC_GAIN: gain = data[15:0];
      pmot_pkg::REG_START_LENGTH: begin
        period = data[31:0];
        cur_len = data[31:0];
      end
      pmot_pkg::REG_COMP_COUNT: n_comp = data[2:0];
      pmot_pkg::REG_COMP_A, pmot_pkg::REG_COMP_B, pmot_pkg::REG_COMP_C,
      pmot_pkg::REG_COMP_D: comp[idx - pmot_pkg::REG_COMP_A] = data;
      default: ;
    endcase
  endfunction

  // first-quadrant cosine in Q30, p in 0..16384
  function longint unsigned qtr_cos_q30(longint unsigned p);
    longint unsigned u, u2, b, t;
    u  = p << 16;
    u2 = (u * u) >> 30;
    b  = 64'd22401992 - ((u2 * 64'd987046) >> 30);
    b  = 64'd272375557 - ((u2 * b) >> 30);
    b  = 64'd1324675879 - ((u2 * b) >> 30);
    t  = (u2 * b) >> 30;
    return (t >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - t;
  endfunction

  // table cosine of a turn fraction, Q1.15
  function longint table_cos(logic [15:0] turn);
    logic [15:0] a;
    logic [1:0] q;
    longint unsigned v, r;
    a = (turn >> (16 - pmot_pkg::COS_TABLE_BITS)) << (16 - pmot_pkg::COS_TABLE_BITS);
    q = a[15:14];
    v = (q == 2'd0 || q == 2'd2) ? qtr_cos_q30(a[13:0]) : qtr_cos_q30(16384 - a[13:0]);
    r = (v + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return (q == 2'd1 || q == 2'd2) ? -longint'(r) : longint'(r);
  endfunction

  function longint level_q30(logic [31:0] t);
    longint acc, amp;
    longint unsigned rem, frac;
    int n;
    logic [15:0] fr;
    acc = longint'($signed(gain)) * 32768;
    n = (n_comp > pmot_pkg::MAX_COMPONENTS) ? pmot_pkg::MAX_COMPONENTS : n_comp;
    for (int i = 0; i < n; i++) begin
      amp = longint'($signed(comp[i][47:32]));
      fr = comp[i][31:16];
      frac = 0;
      if (cur_len != 0) begin
        rem = (longint'(t) * longint'(fr)) % longint'(cur_len);
        frac = (rem << 16) / longint'(cur_len);
      end
      acc += 2 * amp * table_cos(16'(frac) + comp[i][15:0]);
    end
    return acc;
  endfunction

  // corrected state the next add item will report
  function logic next_add_bit();
    return (level_q30(cur_len) > 64'sd536870912) ^ n_outliers[0];
  endfunction

  function void note_item(pmot_pkg::in_item_t it);
    pmot_pkg::result_t r;
    int unsigned k;
    r = '0;
    if (it.mode == pmot_pkg::MODE_ADD) begin
      n_add++;
      r.state_bit = next_add_bit();
      if (r.state_bit != it.observed_bit) begin
        if (n_outliers < pmot_pkg::OUTLIER_DEPTH) begin
          outlier_pos[n_outliers] = cur_len;
          n_outliers++;
          r.outlier_added = 1'b1;
          n_added++;
        end else begin
          r.store_full = 1'b1;
          n_full++;
        end
      end
      cur_len = cur_len + 1;
    end else begin
      n_ret++;
      for (k = 0; k < n_outliers; k++)
        if (it.query_time < outlier_pos[k]) break;
      r.state_bit = (level_q30(it.query_time) >= 64'sd536870912) ^ k[0];
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(pmot_pkg::result_t got);
    pmot_pkg::result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result %b", got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.state_bit !== e.state_bit) begin
      $error("state_bit: expected %b actual %b", e.state_bit, got.state_bit);
      errors++;
    end
    if (got.outlier_added !== e.outlier_added) begin
      $error("outlier_added: expected %b actual %b", e.outlier_added, got.outlier_added);
      errors++;
    end
    if (got.store_full !== e.store_full) begin
      $error("store_full: expected %b actual %b", e.store_full, got.store_full);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pmot_pkg::in_item_t item_i = '0;
  logic               res_strobe_o;
  pmot_pkg::result_t  res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [47:0]        cfg_data_i = '0;

  pmot_scoreboard sb = new();
  int burst_left = 0;

  periodic_model_outlier_tracker_top u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (res_strobe_o) sb.check_result(res_o);
    end
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // drop start so no stale item is taken while the register is written
  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    @(negedge clk_i);
    start       = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // hold start high until the item is taken; keep it high if the burst goes on or the send is not paced
  task automatic send(logic m, logic [31:0] qt, logic ob, bit paced);
    @(negedge clk_i);
    start = 1'b1;
    item_i.mode = m;
    item_i.query_time = qt;
    item_i.observed_bit = ob;
    do @(posedge clk_i); while (busy);
    if (paced) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 7);
        @(negedge clk_i);
        start = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_comp();
    logic [15:0] fr;
    fr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    return {16'($urandom), fr, 16'($urandom)};
  endfunction

  task automatic random_items(int n);
    logic [31:0] qt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        send(pmot_pkg::MODE_ADD, $urandom, $urandom_range(0, 1), 1'b1);
      end else begin
        case ($urandom_range(0, 2))
          0: qt = $urandom;
          1: qt = sb.cur_len - $urandom_range(0, 40);
          default: qt = sb.n_outliers ? sb.outlier_pos[$urandom_range(0, sb.n_outliers - 1)]
                                      : $urandom;
        endcase
        send(pmot_pkg::MODE_RETRIEVE, qt, $urandom_range(0, 1), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults after reset
    send(pmot_pkg::MODE_ADD, 32'h0, 1'b0, 1'b0);
    send(pmot_pkg::MODE_ADD, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'h0, 1'b0, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain();

    write_reg(pmot_pkg::REG_DC_GAIN, 48'h4000);
    write_reg(pmot_pkg::REG_COMP_COUNT, 48'd7);
    write_reg(pmot_pkg::REG_COMP_A, {16'h7FFF, 16'd1, 16'h0000});
    write_reg(pmot_pkg::REG_COMP_B, {16'h8000, 16'hFFFF, 16'hFFFF});
    write_reg(pmot_pkg::REG_COMP_C, {16'h2000, 16'd3, 16'h4000});
    write_reg(pmot_pkg::REG_COMP_D, {16'hE000, 16'd0, 16'h8000});
    write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    // walk the length through its wrap and through zero
    write_reg(pmot_pkg::REG_START_LENGTH, 48'hFFFF_FFFE);
    for (int i = 0; i < 4; i++) send(pmot_pkg::MODE_ADD, 32'h0, i[0], 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'h0, 1'b0, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'hFFFF_FFFE, 1'b0, 1'b0);
    drain();
    write_reg(pmot_pkg::REG_DC_GAIN, 48'h8000);
    write_reg(pmot_pkg::REG_START_LENGTH, 48'd1);
    send(pmot_pkg::MODE_ADD, 32'h0, 1'b1, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'd1, 1'b1, 1'b0);
    drain();
    write_reg(pmot_pkg::REG_DC_GAIN, 48'h7FFF);
    send(pmot_pkg::MODE_ADD, 32'h0, 1'b0, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'd5, 1'b0, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(pmot_pkg::REG_DC_GAIN, 48'h8000);
        1: write_reg(pmot_pkg::REG_DC_GAIN, 48'h7FFF);
        2: write_reg(pmot_pkg::REG_DC_GAIN, 48'h4000);
        default: write_reg(pmot_pkg::REG_DC_GAIN, {32'h0, 16'($urandom)});
      endcase
      write_reg(pmot_pkg::REG_START_LENGTH,
                ($urandom_range(0, 3) == 0) ? {16'h0, 32'($urandom)}
                                            : 48'($urandom_range(1, 200)));
      write_reg(pmot_pkg::REG_COMP_COUNT, 48'($urandom_range(0, 7)));
      write_reg(pmot_pkg::REG_COMP_A, rand_comp());
      write_reg(pmot_pkg::REG_COMP_B, rand_comp());
      write_reg(pmot_pkg::REG_COMP_C, rand_comp());
      write_reg(pmot_pkg::REG_COMP_D, rand_comp());
      random_items(80);
      drain();
    end

    // force a run of outliers with a plain constant model
    write_reg(pmot_pkg::REG_COMP_COUNT, 48'd0);
    write_reg(pmot_pkg::REG_DC_GAIN, 48'h0);
    for (int i = 0; i < 40; i++) begin
      @(negedge clk_i);
      send(pmot_pkg::MODE_ADD, 32'h0, ~sb.next_add_bit(), 1'b0);
    end
    @(negedge clk_i);
    send(pmot_pkg::MODE_ADD, 32'h0, sb.next_add_bit(), 1'b0);
    write_reg(pmot_pkg::REG_COMP_COUNT, 48'd2);
    for (int i = 0; i < 6; i++) send(pmot_pkg::MODE_RETRIEVE, $urandom, 1'b0, 1'b0);
    send(pmot_pkg::MODE_RETRIEVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
    drain();
    repeat (40) @(posedge clk_i);

    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("covered %0d add and %0d retrieve items", sb.n_add, sb.n_ret);
    $display("%0d outliers stored, %0d dropped on a full store", sb.n_added, sb.n_full);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
